### rtl/erpm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Encoder speed estimator package
// Shared widths, constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package erpm_pkg;

  localparam int COUNT_BITS = 16;
  localparam int TIME_BITS  = 32;
  localparam int CPR_W      = 16;
  localparam int RPM_W      = 16;
  localparam int MPM_W      = 26;
  localparam int NUM_W      = COUNT_BITS + MPM_W;
  localparam int DEN_W      = CPR_W + TIME_BITS;
  localparam int REM_W      = DEN_W + 1;
  localparam int STEP_W     = $clog2(NUM_W);
  localparam int IN_DATA_W  = COUNT_BITS + TIME_BITS;

  localparam logic [MPM_W-1:0] MICROS_PER_MIN = MPM_W'(60000000);
  localparam logic [CPR_W-1:0] CPR_RESET      = CPR_W'(2048);
  localparam logic [RPM_W-1:0] RPM_POS_MAX    = RPM_W'(16'h7FFF);
  localparam logic [RPM_W-1:0] RPM_NEG_MIN    = RPM_W'(16'h8000);

  localparam logic MODE_SAMPLE   = 1'b0;
  localparam logic MODE_BASELINE = 1'b1;

  typedef struct packed {
    logic accept;
    logic mul;
    logic step;
    logic resolve;
    logic finish;
  } erpm_cmd_t;

  typedef struct packed {
    logic fast;
    logic div_last;
  } erpm_stat_t;

endpackage : erpm_pkg
`default_nettype wire

### rtl/erpm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Encoder speed estimator controller
// Sequences accept, multiply, serial divide, resolve and output load.
// ----------------------------------------------------------------------------
module erpm_ctrl
  import erpm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  input  wire erpm_stat_t stat,
  output erpm_cmd_t       cmd
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_MUL     = 3'd1;
  localparam logic [2:0] ST_DIV     = 3'd2;
  localparam logic [2:0] ST_RESOLVE = 3'd3;
  localparam logic [2:0] ST_DONE    = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_tready   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = stat.fast ? ST_DONE : ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        if (stat.div_last) begin
          state_nxt = ST_RESOLVE;
        end
      end
      ST_RESOLVE: begin
        cmd.resolve = 1'b1;
        state_nxt   = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule : erpm_ctrl
`default_nettype wire

### rtl/erpm_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Encoder speed estimator datapath
// Baseline state, scaling multiplies, restoring divider and output register.
// ----------------------------------------------------------------------------
module erpm_dp
  import erpm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_mode,
  input  wire logic [COUNT_BITS-1:0] in_count,
  input  wire logic [TIME_BITS-1:0]  in_time,
  input  wire logic                  cfg_we,
  input  wire logic [CPR_W-1:0]      cfg_cpr,
  input  wire erpm_cmd_t             cmd,
  output erpm_stat_t                 stat,
  output logic [RPM_W-1:0]           out_rpm,
  output logic                       out_clip,
  output logic                       out_refresh
);

  logic [CPR_W-1:0]      cpr_r;
  logic [COUNT_BITS-1:0] last_count_r;
  logic [TIME_BITS-1:0]  last_time_r;
  logic [RPM_W-1:0]      held_rpm_r;
  logic                  held_clip_r;
  logic [COUNT_BITS-1:0] mag_r;
  logic                  neg_r;
  logic [TIME_BITS-1:0]  dt_r;
  logic [NUM_W-1:0]      quo_r;
  logic [DEN_W-1:0]      den_r;
  logic [DEN_W-1:0]      rem_r;
  logic [STEP_W-1:0]     step_r;
  logic [RPM_W-1:0]      res_rpm_r;
  logic                  res_clip_r;
  logic                  res_refresh_r;
  logic [RPM_W-1:0]      out_rpm_r;
  logic                  out_clip_r;
  logic                  out_refresh_r;

  logic [TIME_BITS-1:0]  dt;
  logic [COUNT_BITS-1:0] delta;
  logic                  delta_neg;
  logic [COUNT_BITS-1:0] delta_mag;
  logic [CPR_W-1:0]      cpr_eff;
  logic [REM_W-1:0]      rem_sh;
  logic [REM_W-1:0]      rem_diff;
  logic                  q_bit;
  logic [NUM_W-1:0]      limit;
  logic                  clip;
  logic                  round_up;
  logic [NUM_W-1:0]      q_round;
  logic [RPM_W-1:0]      rpm_mag;

  function automatic logic [RPM_W-1:0] res_rpm_nxt_f(input logic c, input logic n,
                                                     input logic [RPM_W-1:0] m);
    logic [RPM_W-1:0] v;
    begin
      if (c) begin
        v = n ? RPM_NEG_MIN : RPM_POS_MAX;
      end else begin
        v = n ? (~m + RPM_W'(1)) : m;
      end
      return v;
    end
  endfunction

  assign dt        = in_time - last_time_r;
  assign delta     = in_count - last_count_r;
  assign delta_neg = delta[COUNT_BITS-1];
  assign delta_mag = delta_neg ? (~delta + COUNT_BITS'(1)) : delta;
  assign cpr_eff   = (cpr_r == '0) ? CPR_W'(1) : cpr_r;

  assign stat.fast     = (in_mode == MODE_BASELINE) || (dt == '0);
  assign stat.div_last = (step_r == STEP_W'(NUM_W - 1));

  assign rem_sh   = {rem_r, quo_r[NUM_W-1]};
  assign rem_diff = rem_sh - {1'b0, den_r};
  assign q_bit    = (rem_sh >= {1'b0, den_r});

  assign limit    = neg_r ? NUM_W'(32768) : NUM_W'(32767);
  assign clip     = (quo_r > limit) || ((quo_r == limit) && (rem_r != '0));
  assign round_up = ({rem_r, 1'b0} >= {1'b0, den_r});
  assign q_round  = quo_r + NUM_W'(round_up);
  assign rpm_mag  = q_round[RPM_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpr_r        <= CPR_RESET;
      last_count_r <= '0;
      last_time_r  <= '0;
      held_rpm_r   <= '0;
      held_clip_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        cpr_r <= cfg_cpr;
      end
      if (cmd.accept) begin
        if (in_mode == MODE_BASELINE) begin
          last_count_r <= in_count;
          last_time_r  <= in_time;
          held_rpm_r   <= '0;
          held_clip_r  <= 1'b0;
        end else if (dt != '0) begin
          last_count_r <= in_count;
          last_time_r  <= in_time;
        end
      end
      if (cmd.resolve) begin
        held_rpm_r  <= res_rpm_nxt_f(clip, neg_r, rpm_mag);
        held_clip_r <= clip;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mag_r <= delta_mag;
      neg_r <= delta_neg;
      dt_r  <= dt;
      if (in_mode == MODE_BASELINE) begin
        res_rpm_r     <= '0;
        res_clip_r    <= 1'b0;
        res_refresh_r <= 1'b0;
      end else begin
        res_rpm_r     <= held_rpm_r;
        res_clip_r    <= held_clip_r;
        res_refresh_r <= 1'b0;
      end
    end
    if (cmd.mul) begin
      quo_r  <= NUM_W'(mag_r) * NUM_W'(MICROS_PER_MIN);
      den_r  <= DEN_W'(cpr_eff) * DEN_W'(dt_r);
      rem_r  <= '0;
      step_r <= '0;
    end
    if (cmd.step) begin
      quo_r  <= {quo_r[NUM_W-2:0], q_bit};
      rem_r  <= q_bit ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      step_r <= step_r + STEP_W'(1);
    end
    if (cmd.resolve) begin
      res_rpm_r     <= res_rpm_nxt_f(clip, neg_r, rpm_mag);
      res_clip_r    <= clip;
      res_refresh_r <= 1'b1;
    end
    if (cmd.finish) begin
      out_rpm_r     <= res_rpm_r;
      out_clip_r    <= res_clip_r;
      out_refresh_r <= res_refresh_r;
    end
  end

  assign out_rpm     = out_rpm_r;
  assign out_clip    = out_clip_r;
  assign out_refresh = out_refresh_r;

endmodule : erpm_dp
`default_nettype wire

### rtl/encoder_rpm_estimator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Encoder rpm estimator core
// M-method shaft speed from encoder counter readings and microsecond stamps.
//
// The input stream carries one reading per transfer: the counter value and
// timestamp in in_tdata and the mode bit in in_tuser. Each input transfer
// yields exactly one output transfer with the signed rpm in out_tdata and
// the clipped and refreshed flags in out_tuser. The cfg channel writes
// counts_per_rev and is always ready; write it only while the core is idle.
// A sample that needs a new estimate passes from one input transfer to the
// next through the accept, a multiply, the restoring divider, a resolve
// step and the output load, which waits while the output register is full.
// Baseline and zero-elapsed-time transfers skip to the output load.
// The result is registered; the next input is accepted while it waits.
// If the receiver stalls, the following result waits in the core and no
// further input is taken until the output register frees up.
// Reset clears the baseline and held speed and sets counts_per_rev to 2048.
// ----------------------------------------------------------------------------
module encoder_rpm_estimator_core
  import erpm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [IN_DATA_W-1:0] in_tdata,   // count_value, time_us
  input  wire logic                 in_tuser,   // mode
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [RPM_W-1:0]          out_tdata,  // speed_rpm
  output logic [1:0]                out_tuser,  // clipped, refreshed
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CPR_W-1:0]     cfg_data
);

  erpm_cmd_t  cmd;
  erpm_stat_t stat;
  logic       out_clip;
  logic       out_refresh;

  assign cfg_ready = 1'b1;

  erpm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  erpm_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mode     (in_tuser),
    .in_count    (in_tdata[COUNT_BITS-1:0]),
    .in_time     (in_tdata[IN_DATA_W-1:COUNT_BITS]),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_cpr     (cfg_data),
    .cmd         (cmd),
    .stat        (stat),
    .out_rpm     (out_tdata),
    .out_clip    (out_clip),
    .out_refresh (out_refresh)
  );

  assign out_tuser = {out_refresh, out_clip};

  a_clip_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> ((out_tdata == RPM_POS_MAX) || (out_tdata == RPM_NEG_MIN)))
    else $error("clipped result is not saturated");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while an item is in progress");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result appeared without a finished item");

endmodule : encoder_rpm_estimator_core
`default_nettype wire

### bench/rpm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Speed result checker for the encoder rpm estimator
// Watches the reading, result and counts_per_rev channels. It keeps its own
// baseline and held speed, works out the rpm that each accepted reading must
// produce, and compares every result transfer field by field in order.
// ----------------------------------------------------------------------------
module rpm_checker
  import erpm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,   // count_value, time_us
  input  logic                 in_tuser,   // mode
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [RPM_W-1:0]     out_tdata,  // speed_rpm
  input  logic [1:0]           out_tuser,  // clipped, refreshed
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CPR_W-1:0]     cfg_data,
  output int                   mismatch_count,
  output int                   outstanding,
  output int                   results_seen,
  output int                   estimates_seen,
  output int                   clipped_seen
);

  typedef struct packed {
    logic [RPM_W-1:0] speed;
    logic             clipped;
    logic             refreshed;
  } speed_t;

  localparam logic [63:0] USEC_PER_MIN = 64'd60000000;

  logic [CPR_W-1:0]      cpr;
  logic [COUNT_BITS-1:0] base_count;
  logic [TIME_BITS-1:0]  base_time;
  logic [RPM_W-1:0]      held_speed;
  logic                  held_clip;
  speed_t                expected_speeds[$];

  function automatic speed_t estimate_speed(logic mode, logic [COUNT_BITS-1:0] count,
                                            logic [TIME_BITS-1:0] stamp);
    speed_t                res;
    logic [TIME_BITS-1:0]  dt;
    logic [COUNT_BITS-1:0] delta;
    logic [COUNT_BITS-1:0] mag16;
    logic [CPR_W-1:0]      divisor;
    logic                  neg;
    logic [63:0]           num;
    logic [63:0]           den;
    logic [63:0]           lim;
    logic [63:0]           q;
    res = '0;
    if (mode == MODE_BASELINE) begin
      base_count = count;
      base_time  = stamp;
      held_speed = '0;
      held_clip  = 1'b0;
      return res;
    end
    dt = stamp - base_time;
    if (dt == '0) begin
      res.speed   = held_speed;
      res.clipped = held_clip;
      return res;
    end
    delta = count - base_count;
    neg   = delta[COUNT_BITS-1];
    mag16 = neg ? (~delta + 1'b1) : delta;
    base_count = count;
    base_time  = stamp;
    divisor = (cpr == '0) ? CPR_W'(1) : cpr;
    num = 64'(mag16) * USEC_PER_MIN;
    den = 64'(divisor) * 64'(dt);
    lim = neg ? 64'd32768 : 64'd32767;
    if (num > lim * den) begin
      res.clipped = 1'b1;
      res.speed   = neg ? RPM_NEG_MIN : RPM_POS_MAX;
    end else begin
      q = (2 * num + den) / (2 * den);
      if (q > lim) q = lim;
      res.speed = neg ? (~q[RPM_W-1:0] + 1'b1) : q[RPM_W-1:0];
    end
    res.refreshed = 1'b1;
    held_speed = res.speed;
    held_clip  = res.clipped;
    return res;
  endfunction

  task automatic report_field(string field, int want, int got);
    mismatch_count++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  always @(posedge clk) begin
    speed_t got;
    speed_t want;
    if (!rst_n) begin
      cpr        = CPR_RESET;
      base_count = '0;
      base_time  = '0;
      held_speed = '0;
      held_clip  = 1'b0;
      expected_speeds.delete();
      mismatch_count = 0;
      results_seen   = 0;
      estimates_seen = 0;
      clipped_seen   = 0;
      outstanding   <= 0;
    end else begin
      if (cfg_valid && cfg_ready) cpr = cfg_data;
      if (out_tvalid && out_tready) begin
        got.speed     = out_tdata;
        got.clipped   = out_tuser[0];
        got.refreshed = out_tuser[1];
        results_seen++;
        if (expected_speeds.size() == 0) begin
          mismatch_count++;
          $display("%0t: result transfer with nothing expected, speed_rpm %0d", $time,
                   $signed(got.speed));
        end else begin
          want = expected_speeds.pop_front();
          if (got.speed !== want.speed)
            report_field("speed_rpm", int'($signed(want.speed)), int'($signed(got.speed)));
          if (got.clipped !== want.clipped)
            report_field("clipped", int'(want.clipped), int'(got.clipped));
          if (got.refreshed !== want.refreshed)
            report_field("refreshed", int'(want.refreshed), int'(got.refreshed));
          if (want.refreshed) estimates_seen++;
          if (want.clipped) clipped_seen++;
        end
      end
      if (in_tvalid && in_tready)
        expected_speeds.push_back(estimate_speed(in_tuser, in_tdata[COUNT_BITS-1:0],
                                                 in_tdata[IN_DATA_W-1:COUNT_BITS]));
      outstanding <= expected_speeds.size();
    end
  end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the encoder rpm estimator core
// Drives encoder readings and counts_per_rev writes with random gaps and
// output stalls. A directed part covers held speed, counter wrap, rounding
// of halves, saturation and baselines; random phases then sweep several
// counts_per_rev settings, including the extremes, while a checker compares
// every result against its own prediction.
// ----------------------------------------------------------------------------
module testbench;
  import erpm_pkg::*;

  localparam int RANDOM_READINGS = 1430;
  localparam int PHASES = 8;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // count_value, time_us
  logic                  in_tuser = 1'b0; // mode
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [RPM_W-1:0]      out_tdata;       // speed_rpm
  logic [1:0]            out_tuser;       // clipped, refreshed
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CPR_W-1:0]      cfg_data = '0;
  logic                  quiet = 1'b0;

  int mismatches;
  int outstanding;
  int results_seen;
  int estimates_seen;
  int clipped_seen;
  int readings_sent = 0;
  int settings_used = 1;

  logic [CPR_W-1:0]      cpr_now = CPR_RESET;
  logic [COUNT_BITS-1:0] count_now = '0;
  logic [TIME_BITS-1:0]  time_now = '0;

  encoder_rpm_estimator_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  rpm_checker speed_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatches),
    .outstanding    (outstanding),
    .results_seen   (results_seen),
    .estimates_seen (estimates_seen),
    .clipped_seen   (clipped_seen)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  task automatic send_reading(logic mode, logic [COUNT_BITS-1:0] count,
                              logic [TIME_BITS-1:0] stamp);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {stamp, count};
    in_tuser  <= mode;
    do @(posedge clk); while (!in_tready);
    count_now = count;
    time_now  = stamp;
    readings_sent++;
  endtask

  task automatic write_cpr(logic [CPR_W-1:0] value);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cpr_now = value;
    settings_used++;
  endtask

  task automatic send_random_reading();
    int                    pick;
    int                    r;
    logic [COUNT_BITS-1:0] delta;
    logic [TIME_BITS-1:0]  dt;
    longint unsigned       mag;
    longint unsigned       eff;
    longint unsigned       target;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      send_reading(MODE_BASELINE, COUNT_BITS'($urandom), $urandom);
      return;
    end
    if (pick < 10) begin
      send_reading(MODE_SAMPLE, COUNT_BITS'($urandom), $urandom);
      return;
    end
    r = $urandom_range(0, 99);
    if (r < 40) delta = COUNT_BITS'($urandom_range(0, 64));
    else if (r < 70) delta = COUNT_BITS'($urandom_range(0, 2000));
    else if (r < 90) delta = COUNT_BITS'($urandom);
    else delta = COUNT_BITS'($urandom_range(32767, 32769));
    if ($urandom_range(0, 1)) delta = ~delta + 1'b1;
    r = $urandom_range(0, 99);
    if (pick < 16) begin
      dt = '0;
    end else if (pick < 30) begin
      mag    = $urandom_range(1, 3000);
      eff    = (cpr_now == '0) ? 1 : longint'(cpr_now);
      target = $urandom_range(16000, 40000);
      dt = TIME_BITS'((mag * 60000000) / (eff * target));
      if ($urandom_range(0, 1)) dt = dt + 1'b1;
      if (dt == '0) dt = 1;
      delta = COUNT_BITS'(mag);
      if ($urandom_range(0, 1)) delta = ~delta + 1'b1;
    end else if (r < 30) begin
      dt = $urandom_range(1, 100);
    end else if (r < 70) begin
      dt = $urandom_range(100, 100000);
    end else if (r < 90) begin
      dt = $urandom_range(100000, 50000000);
    end else begin
      dt = $urandom;
    end
    send_reading(MODE_SAMPLE, count_now + delta, time_now + dt);
  endtask

  initial begin
    int stall;
    @(posedge clk);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  initial begin
    forever begin
      repeat ($urandom_range(300, 1500)) @(posedge clk);
      quiet <= 1'b1;
      repeat ($urandom_range(100, 400)) @(posedge clk);
      quiet <= 1'b0;
    end
  end

  initial begin
    logic [CPR_W-1:0] settings [PHASES];
    int               n;
    settings[0] = 16'hFFFF;
    settings[1] = 16'h0000;
    settings[2] = CPR_RESET;
    settings[3] = 16'd1;
    settings[4] = CPR_W'($urandom_range(1, 65535));
    settings[5] = CPR_W'($urandom_range(2, 500));
    settings[6] = 16'd360;
    settings[7] = CPR_W'($urandom_range(1, 65535));
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_reading(MODE_SAMPLE,   16'h0000, 32'h0000_0000);
    send_reading(MODE_SAMPLE,   16'h0004, 32'h0000_0005);
    send_reading(MODE_SAMPLE,   16'h0000, 32'h0000_000A);
    send_reading(MODE_SAMPLE,   16'h0000, 32'h0000_000A);
    send_reading(MODE_SAMPLE,   16'h1234, 32'h0000_000A);
    send_reading(MODE_BASELINE, 16'hFFFF, 32'hFFFF_FFFF);
    send_reading(MODE_SAMPLE,   16'h0001, 32'h0000_0003);
    send_reading(MODE_SAMPLE,   16'h8001, 32'h0000_0004);
    send_reading(MODE_SAMPLE,   16'h0000, 32'h0000_0005);
    send_reading(MODE_SAMPLE,   16'h0001, 32'h0000_0004);
    send_reading(MODE_SAMPLE,   16'h0000, 32'h0000_0003);
    send_reading(MODE_SAMPLE,   16'h0000, 32'h0000_0003);
    send_reading(MODE_SAMPLE,   16'h0001, 32'h0000_0004);
    send_reading(MODE_SAMPLE,   16'h0000, 32'h0000_0005);
    send_reading(MODE_BASELINE, 16'h0000, 32'h8000_0000);
    send_reading(MODE_SAMPLE,   16'h0007, 32'h8000_0006);
    send_reading(MODE_SAMPLE,   16'h7FFF, 32'hFFFF_FFFF);
    send_reading(MODE_BASELINE, 16'h5555, 32'hAAAA_AAAA);
    send_reading(MODE_SAMPLE,   16'hAAAA, 32'h5555_5555);
    write_cpr(16'd1);
    send_reading(MODE_BASELINE, 16'h0000, 32'h0000_0000);
    send_reading(MODE_SAMPLE,   16'h0001, 32'h0000_1E00);
    send_reading(MODE_SAMPLE,   16'h0000, 32'h0000_3C00);

    for (int p = 0; p < PHASES; p++) begin
      write_cpr(settings[p]);
      repeat (RANDOM_READINGS / PHASES) send_random_reading();
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    for (n = 0; n < 20000 && outstanding != 0; n++) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Sent %0d readings over %0d counts_per_rev settings; checked %0d results.",
             readings_sent, settings_used, results_seen);
    $display("Of those, %0d were fresh estimates and %0d were saturated.",
             estimates_seen, clipped_seen);
    if (mismatches == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
